@@ rtl/core/wra_pkg.sv @@
`timescale 1ns / 1ps

package wra_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int COEF_W     = 16;
    localparam int STATE_FRAC = 16;

    localparam int RUN_W   = SAMPLE_W + STATE_FRAC;
    localparam int ACC_W   = RUN_W + COEF_W + 1;
    localparam int MAG_W   = ACC_W - 1;
    localparam int DEN_W   = COEF_W + 1;
    localparam int CBIT_W  = $clog2(COEF_W);
    localparam int CNT_W   = $clog2(RUN_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_START = CFG_IDX_W'(2);

    localparam logic [COEF_W-1:0] ALPHA_RST = COEF_W'(0);
    localparam logic [COEF_W-1:0] BETA_RST  = COEF_W'(4096);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_MAG,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic step;
    } t_mac_ctl;

    typedef struct packed {
        logic start;
        logic step;
    } t_div_ctl;

endpackage

@@ rtl/core/wra_mac.sv @@
`timescale 1ns / 1ps

module wra_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wra_pkg::t_mac_ctl             i_ctl,
    input  logic [wra_pkg::COEF_W-1:0]    i_coef,
    input  logic [wra_pkg::ACC_W-1:0]     i_oper,
    output logic [wra_pkg::ACC_W-1:0]     o_acc
);

    logic [wra_pkg::ACC_W-1:0]  r_acc;
    logic [wra_pkg::ACC_W-1:0]  r_mop;
    logic [wra_pkg::COEF_W-1:0] r_coef;
    logic [wra_pkg::CBIT_W-1:0] r_bit;
    logic                       w_sub;

    assign w_sub = (r_bit == wra_pkg::CBIT_W'(wra_pkg::COEF_W - 1));
    assign o_acc = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_ctl.load) begin
            r_bit <= '0;
        end else if (i_ctl.step) begin
            r_bit <= r_bit + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.step && r_coef[0]) begin
            r_acc <= w_sub ? r_acc - r_mop : r_acc + r_mop;
        end
        if (i_ctl.load) begin
            r_mop  <= i_oper;
            r_coef <= i_coef;
        end else if (i_ctl.step) begin
            r_mop  <= {r_mop[wra_pkg::ACC_W-2:0], 1'b0};
            r_coef <= {1'b0, r_coef[wra_pkg::COEF_W-1:1]};
        end
    end

endmodule

@@ rtl/core/wra_div.sv @@
`timescale 1ns / 1ps

module wra_div (
    input  logic                          i_clk,
    input  wra_pkg::t_div_ctl             i_ctl,
    input  logic [wra_pkg::MAG_W-1:0]     i_mag,
    input  logic [wra_pkg::DEN_W-1:0]     i_den,
    output logic [wra_pkg::RUN_W-1:0]     o_quo,
    output logic                          o_ovf
);

    logic [wra_pkg::DEN_W-1:0] r_rem;
    logic [wra_pkg::RUN_W-1:0] r_dq;
    logic                      r_ovf;
    logic [wra_pkg::DEN_W:0]   w_cur;
    logic                      w_ge;
    logic [wra_pkg::DEN_W:0]   w_diff;
    logic [wra_pkg::DEN_W-1:0] w_hi;

    assign w_hi   = {1'b0, i_mag[wra_pkg::MAG_W-1:wra_pkg::RUN_W]};
    assign w_cur  = {r_rem, r_dq[wra_pkg::RUN_W-1]};
    assign w_ge   = (w_cur >= {1'b0, i_den});
    assign w_diff = w_cur - {1'b0, i_den};
    assign o_quo  = r_dq;
    assign o_ovf  = r_ovf;

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= w_hi;
            r_dq  <= i_mag[wra_pkg::RUN_W-1:0];
            r_ovf <= (w_hi >= i_den);
        end else if (i_ctl.step) begin
            r_rem <= w_ge ? w_diff[wra_pkg::DEN_W-1:0] : w_cur[wra_pkg::DEN_W-1:0];
            r_dq  <= {r_dq[wra_pkg::RUN_W-2:0], w_ge};
        end
    end

endmodule

@@ rtl/core/weighted_recursive_average.sv @@
`timescale 1ns / 1ps
// A transaction passes S_MUL, S_MAG, S_DIV and S_FIN to output valid (S_FIN directly
// when alpha+beta is zero); no new sample is taken until S_IDLE: 32 shift-add multiply
// steps on one accumulator adder, a magnitude step and 48 restoring divide steps.
// The finished result is held in an output register while the next sample is taken.
// Reset (synchronous, active low): alpha 0, beta 4096, start value 0, running value 0,
// next sample begins a run, output empty.

module weighted_recursive_average (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [wra_pkg::SAMPLE_W-1:0]       i_sample,
    input  logic                               i_last_of_run,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [wra_pkg::SAMPLE_W-1:0]       o_filtered_value,
    output logic                               o_last_out,
    input  logic                               i_cfg_wr_en,
    input  logic [wra_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wra_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int W  = wra_pkg::SAMPLE_W;
    localparam int F  = wra_pkg::STATE_FRAC;
    localparam int RW = wra_pkg::RUN_W;
    localparam int AW = wra_pkg::ACC_W;
    localparam int DW = wra_pkg::DEN_W;
    localparam int CW = wra_pkg::COEF_W;

    wra_pkg::t_state r_state, n_state;
    logic [wra_pkg::CNT_W-1:0] r_cnt, n_cnt;

    logic [CW-1:0] r_alpha, r_beta;
    logic [W-1:0]  r_start;
    logic [RW-1:0] r_run;
    logic          r_fresh;
    logic [W-1:0]  r_samp;
    logic          r_last;
    logic [DW-1:0] r_den;
    logic          r_zero;
    logic          r_neg;
    logic          r_ovalid;
    logic [W-1:0]  r_y;
    logic          r_olast;

    logic              w_accept;
    logic              w_out_free;
    logic [RW-1:0]     w_prev;
    logic [DW-1:0]     w_den;
    logic [DW-1:0]     w_md;
    wra_pkg::t_mac_ctl w_mac_ctl;
    wra_pkg::t_div_ctl w_div_ctl;
    logic [CW-1:0]     w_coef;
    logic [AW-1:0]     w_oper;
    logic [AW-1:0]     w_acc;
    logic [AW-1:0]     w_acc_abs;
    logic [RW-1:0]     w_quo;
    logic              w_ovf;
    logic              w_nq;
    logic [RW-1:0]     w_lim;
    logic [RW-1:0]     w_qs;
    logic [RW-1:0]     w_run_new;
    logic [RW-1:0]     w_biased;
    logic [W-1:0]      w_ip;
    logic [F-1:0]      w_frac;
    logic              w_inc;
    logic [W:0]        w_ip_rnd;
    logic [W-1:0]      w_y;

    assign w_accept   = i_valid && (r_state == wra_pkg::S_IDLE);
    assign o_stall    = (r_state != wra_pkg::S_IDLE);
    assign w_out_free = !r_ovalid || !i_stall;

    assign w_prev = r_fresh ? {r_start, {F{1'b0}}} : r_run;
    assign w_den  = {r_alpha[CW-1], r_alpha} + {r_beta[CW-1], r_beta};
    assign w_md   = r_den[DW-1] ? DW'(0) - r_den : r_den;

    assign w_mac_ctl.clear = w_accept;
    assign w_mac_ctl.load  = w_accept ||
                             ((r_state == wra_pkg::S_MUL) &&
                              (r_cnt == wra_pkg::CNT_W'(CW - 1)));
    assign w_mac_ctl.step  = (r_state == wra_pkg::S_MUL);
    assign w_coef = w_accept ? r_alpha : r_beta;
    assign w_oper = w_accept ? {{(AW - RW){w_prev[RW-1]}}, w_prev}
                             : {{(AW - RW){r_samp[W-1]}}, r_samp, {F{1'b0}}};

    assign w_acc_abs = w_acc[AW-1] ? AW'(0) - w_acc : w_acc;
    assign w_div_ctl.start = (r_state == wra_pkg::S_MAG);
    assign w_div_ctl.step  = (r_state == wra_pkg::S_DIV);

    wra_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_coef  (w_coef),
        .i_oper  (w_oper),
        .o_acc   (w_acc)
    );

    wra_div u_div (
        .i_clk (i_clk),
        .i_ctl (w_div_ctl),
        .i_mag (w_acc_abs[wra_pkg::MAG_W-1:0]),
        .i_den (w_md),
        .o_quo (w_quo),
        .o_ovf (w_ovf)
    );

    // saturate quotient, apply sign, round half to even
    assign w_nq      = r_neg && (w_ovf || (w_quo != '0));
    assign w_lim     = {1'b0, {(RW - 1){1'b1}}} + RW'(w_nq);
    assign w_qs      = (w_ovf || (w_quo > w_lim)) ? w_lim : w_quo;
    assign w_run_new = w_nq ? RW'(0) - w_qs : w_qs;
    assign w_biased  = {~w_run_new[RW-1], w_run_new[RW-2:0]};
    assign w_ip      = w_biased[RW-1:F];
    assign w_frac    = w_biased[F-1:0];
    assign w_inc     = (w_frac > {1'b1, {(F - 1){1'b0}}}) ||
                       ((w_frac == {1'b1, {(F - 1){1'b0}}}) && w_ip[0]);
    assign w_ip_rnd  = {1'b0, w_ip} + (W + 1)'(w_inc);
    assign w_y       = w_ip_rnd[W] ? {1'b0, {(W - 1){1'b1}}}
                                   : {~w_ip_rnd[W-1], w_ip_rnd[W-2:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wra_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            wra_pkg::S_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    n_state = (w_den == '0) ? wra_pkg::S_FIN : wra_pkg::S_MUL;
                end
            end
            wra_pkg::S_MUL: begin
                if (r_cnt == wra_pkg::CNT_W'(2 * CW - 1)) begin
                    n_state = wra_pkg::S_MAG;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            wra_pkg::S_MAG: begin
                n_state = wra_pkg::S_DIV;
                n_cnt   = '0;
            end
            wra_pkg::S_DIV: begin
                if (r_cnt == wra_pkg::CNT_W'(RW - 1)) begin
                    n_state = wra_pkg::S_FIN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            wra_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_state = wra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wra_pkg::S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= wra_pkg::ALPHA_RST;
            r_beta  <= wra_pkg::BETA_RST;
            r_start <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                wra_pkg::CFG_ALPHA: r_alpha <= i_cfg_data[CW-1:0];
                wra_pkg::CFG_BETA:  r_beta  <= i_cfg_data[CW-1:0];
                wra_pkg::CFG_START: r_start <= i_cfg_data[W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= '0;
            r_fresh  <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_run   <= w_prev;
                r_fresh <= i_last_of_run;
            end else if ((r_state == wra_pkg::S_FIN) && w_out_free && !r_zero) begin
                r_run <= w_run_new;
            end
            if ((r_state == wra_pkg::S_FIN) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_samp <= i_sample;
            r_last <= i_last_of_run;
            r_den  <= w_den;
            r_zero <= (w_den == '0);
        end
        if (r_state == wra_pkg::S_MAG) begin
            r_neg <= w_acc[AW-1] ^ r_den[DW-1];
        end
        if ((r_state == wra_pkg::S_FIN) && w_out_free) begin
            r_y     <= r_zero ? W'(1) : w_y;
            r_olast <= r_last;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_filtered_value = r_y;
    assign o_last_out       = r_olast;

    a_rise_from_fin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == wra_pkg::S_FIN))
        else $error("output valid rose without a finished transaction");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != wra_pkg::S_IDLE))
        else $error("sequencer idle right after an input transaction");

    a_fresh_tracks_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_fresh == $past(i_last_of_run)))
        else $error("run start flag does not follow last_of_run");

    a_div_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wra_pkg::S_DIV) |-> (r_cnt < wra_pkg::CNT_W'(RW)))
        else $error("divide step count out of range");

    a_zero_den_short : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == wra_pkg::S_IDLE) && i_valid && (w_den == '0))
        |=> (r_state == wra_pkg::S_FIN))
        else $error("zero weight sum did not skip to finish");

endmodule
